FILE: hw/rtl/ftb_pkg.sv
// ftb_pkg: shared types and constants of the frame timer bank
// used by ftb_slot_store, ftb_rate_div and frame_timer_bank; no dependencies
`default_nettype none

package ftb_pkg;

	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_ALLOC = 3'd1,
		CMD_FREE  = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_RESET = 3'd5,
		CMD_QUERY = 3'd6,
		CMD_NOP   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_FREE    = 2'd1,
		ST_NOT_ALLOC  = 2'd2,
		ST_UNUSED     = 2'd3
	} status_t;

	// register map
	localparam int PADDR_W = 3;
	localparam logic REG_DEBUG_CLAMP = 1'b0;

	localparam logic [31:0] CLAMP_LIMIT   = 32'd1000;
	localparam logic [31:0] CLAMP_VALUE   = 32'd16;
	localparam logic [31:0] MS_PER_SECOND = 32'd1000;

	// frames * 1000 ms * 256 (8.8 fixed point)
	localparam int DIVIDEND_W = 34;
	localparam logic [DIVIDEND_W-1:0] RATE_SCALE = 34'd256000;
	localparam int QUOT_W = 16;

	typedef struct packed {
		logic elapsed_we;
		logic interval_we;
		logic rd_en;
	} store_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ftb_slot_store.sv
// ftb_slot_store: per-slot elapsed and interval memories, registered read
// depends on ftb_pkg for the control struct
`default_nettype none

module ftb_slot_store
	import ftb_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire store_ctl_t    ctl,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [31:0]   wr_elapsed,
	input  wire logic [31:0]   wr_interval,
	input  wire logic [AW-1:0] rd_addr,
	output logic [31:0]        rd_elapsed,
	output logic [31:0]        rd_interval
);

	logic [31:0] elapsed_mem [DEPTH];
	logic [31:0] interval_mem [DEPTH];
	logic [31:0] rd_elapsed_q;
	logic [31:0] rd_interval_q;

	always_ff @(posedge clk) begin
		if (ctl.elapsed_we) begin
			elapsed_mem[wr_addr] <= wr_elapsed;
		end
		if (ctl.interval_we) begin
			interval_mem[wr_addr] <= wr_interval;
		end
		if (ctl.rd_en) begin
			rd_elapsed_q  <= elapsed_mem[rd_addr];
			rd_interval_q <= interval_mem[rd_addr];
		end
	end

	assign rd_elapsed  = rd_elapsed_q;
	assign rd_interval = rd_interval_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ftb_rate_div.sv
// ftb_rate_div: restoring divider, one quotient bit per cycle, 16-bit saturating result
// depends on ftb_pkg for widths and the status struct
`default_nettype none

module ftb_rate_div
	import ftb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [31:0]           divisor,
	output div_stat_t                  stat,
	output logic [QUOT_W-1:0]          quotient
);

	localparam int CMP_W = 32 + QUOT_W;

	logic              active_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic              sat_q;
	logic [31:0]       rem_q;
	logic [31:0]       div_q;
	logic [QUOT_W-1:0] num_q;
	logic [QUOT_W-1:0] quot_q;
	logic              ovf;
	logic [32:0]       trial;
	logic              fits;

	// quotient of 2^16 or more saturates, so check that up front
	assign ovf   = CMP_W'(dividend) >= {divisor, QUOT_W'(0)};
	assign trial = {rem_q, num_q[QUOT_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= ovf ? 5'd0 : 5'(QUOT_W);
			end else if (active_q) begin
				if (cnt_q == 5'd0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q  <= ovf;
			div_q  <= divisor;
			rem_q  <= 32'(dividend[DIVIDEND_W-1:QUOT_W]);
			num_q  <= dividend[QUOT_W-1:0];
			quot_q <= '0;
		end else if (active_q && cnt_q != 5'd0) begin
			rem_q  <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			num_q  <= {num_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign stat.busy = active_q;
	assign stat.done = done_q;
	assign quotient  = sat_q ? '1 : quot_q;

endmodule

`default_nettype wire

FILE: hw/rtl/frame_timer_bank.sv
// frame_timer_bank: bank of elapsed-time timers advanced by frame ticks
// depends on ftb_pkg, ftb_slot_store and ftb_rate_div
//
// Usage: one command transaction (command, slot, value) on cmd_valid/cmd_stall
// gives exactly one response transaction on rsp_valid/rsp_stall. cmd_stall is
// low only while the sequencer is idle; one command is worked at a time, but a
// finished response may wait in the output register while the next command runs.
// Steps from accept to rsp_valid:
//   start, stop, reset, query: execute, read, report, finish
//   free and bad slot: execute, finish; no-op: finish only
//   allocate: scan up from slot 0 to the lowest free slot (all slots when full)
//   tick: frame time, then a read and a write step per slot on the shared
//   elapsed memory, then the rate step; once per second of accumulated frame
//   time the serial divider refreshes the frame rate before the finish step
// cmd_stall falls in the same cycle that rsp_valid rises.
// Reset clears every slot, the tick history, the rate and the clamp register.
// While rsp_stall is high the response holds and the next result waits in the
// sequencer. debug_clamp_enable is at APB byte address 0.
`default_nettype none

module frame_timer_bank
	import ftb_pkg::*;
#(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [2:0]         command,
	input  wire logic [3:0]         slot,
	input  wire logic [31:0]        value,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [1:0]              status,
	output logic [3:0]              result_slot,
	output logic                    expired,
	output logic                    enabled,
	output logic [31:0]             elapsed,
	output logic [31:0]             interval,
	output logic [31:0]             frame_time,
	output logic [15:0]             frame_rate
);

	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [SW-1:0] IDX_LAST = SW'(TIMER_SLOTS - 1);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_TICK_FT  = 12'b0000_0000_0010,
		S_TICK_RD  = 12'b0000_0000_0100,
		S_TICK_WR  = 12'b0000_0000_1000,
		S_RATE     = 12'b0000_0001_0000,
		S_DIV_GO   = 12'b0000_0010_0000,
		S_DIV_WAIT = 12'b0000_0100_0000,
		S_ALLOC    = 12'b0000_1000_0000,
		S_EXEC     = 12'b0001_0000_0000,
		S_READ     = 12'b0010_0000_0000,
		S_REPORT   = 12'b0100_0000_0000,
		S_FIN      = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic                   clamp_q;
	logic [31:0]            last_tick_q;
	logic [31:0]            frame_delta_q;
	logic [15:0]            rate_count_q;
	logic [31:0]            rate_ms_q;
	logic [15:0]            rate_value_q;
	logic [TIMER_SLOTS-1:0] in_use_q;
	logic [TIMER_SLOTS-1:0] running_q;
	logic [SW-1:0]          idx_q;
	logic                   rsp_valid_q;

	cmd_t                   cmd_q;
	logic [3:0]             slot_q;
	logic [31:0]            value_q;
	logic [DIVIDEND_W-1:0]  prod_q;
	status_t                res_status_q;
	logic [3:0]             res_slot_q;
	logic                   res_expired_q;
	logic                   res_enabled_q;
	logic [31:0]            res_elapsed_q;
	logic [31:0]            res_interval_q;
	status_t                status_q;
	logic [3:0]             result_slot_q;
	logic                   expired_q;
	logic                   enabled_q;
	logic [31:0]            elapsed_q;
	logic [31:0]            interval_q;
	logic [31:0]            frame_time_q;
	logic [15:0]            frame_rate_q;

	logic                   cmd_accept;
	logic                   out_free;
	logic                   cfg_write;
	logic [SW-1:0]          slot_idx;
	logic                   slot_live;
	logic [31:0]            ft_raw;
	logic [31:0]            ft;
	logic [31:0]            add_a;
	logic [32:0]            sum_w;
	logic [31:0]            sat_sum;
	logic                   rate_below;
	store_ctl_t             st_ctl;
	logic [SW-1:0]          st_addr;
	logic [31:0]            rd_elapsed;
	logic [31:0]            rd_interval;
	div_stat_t              div_stat;
	logic [QUOT_W-1:0]      div_quot;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_DEBUG_CLAMP) ? {31'd0, clamp_q} : 32'd0;

	assign cmd_stall  = (state_q != S_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;

	assign slot_idx  = SW'(slot_q);
	assign slot_live = (32'(slot_q) < 32'(TIMER_SLOTS)) && in_use_q[slot_idx];

	assign ft_raw = value_q - last_tick_q;
	assign ft     = (clamp_q && ft_raw > CLAMP_LIMIT) ? CLAMP_VALUE : ft_raw;

	// shared saturating adder: slot elapsed during the walk, rate window otherwise
	assign add_a      = (state_q == S_TICK_WR) ? rd_elapsed : rate_ms_q;
	assign sum_w      = {1'b0, add_a} + {1'b0, frame_delta_q};
	assign sat_sum    = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
	assign rate_below = rate_ms_q < MS_PER_SECOND;

	assign st_ctl.elapsed_we =
		((state_q == S_TICK_WR) && in_use_q[idx_q] && running_q[idx_q]) ||
		((state_q == S_ALLOC) && !in_use_q[idx_q]) ||
		((state_q == S_EXEC) && slot_live && (cmd_q == CMD_RESET));
	assign st_ctl.interval_we = (state_q == S_ALLOC) && !in_use_q[idx_q];
	assign st_ctl.rd_en       = (state_q == S_TICK_RD) || (state_q == S_READ);
	assign st_addr = ((state_q == S_EXEC) || (state_q == S_READ)) ? slot_idx : idx_q;

	ftb_slot_store #(
		.DEPTH(TIMER_SLOTS),
		.AW(SW)
	) u_store (
		.clk(clk),
		.ctl(st_ctl),
		.wr_addr(st_addr),
		.wr_elapsed((state_q == S_TICK_WR) ? sat_sum : 32'd0),
		.wr_interval(value_q),
		.rd_addr(st_addr),
		.rd_elapsed(rd_elapsed),
		.rd_interval(rd_interval)
	);

	ftb_rate_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == S_DIV_GO),
		.dividend(prod_q),
		.divisor(rate_ms_q),
		.stat(div_stat),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			clamp_q       <= 1'b0;
			last_tick_q   <= '0;
			frame_delta_q <= '0;
			rate_count_q  <= '0;
			rate_ms_q     <= '0;
			rate_value_q  <= '0;
			in_use_q      <= '0;
			running_q     <= '0;
			idx_q         <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_write && paddr[2] == REG_DEBUG_CLAMP) begin
				clamp_q <= pwdata[0];
			end
			// a new response replaces the one taken at this edge
			if (state_q == S_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_accept) begin
						idx_q <= '0;
						unique case (command)
							CMD_TICK:  state_q <= S_TICK_FT;
							CMD_ALLOC: state_q <= S_ALLOC;
							CMD_NOP:   state_q <= S_FIN;
							default:   state_q <= S_EXEC;
						endcase
					end
				end
				S_TICK_FT: begin
					last_tick_q   <= value_q;
					frame_delta_q <= ft;
					state_q       <= S_TICK_RD;
				end
				S_TICK_RD: begin
					state_q <= S_TICK_WR;
				end
				S_TICK_WR: begin
					if (idx_q == IDX_LAST) begin
						state_q <= S_RATE;
					end else begin
						idx_q   <= idx_q + SW'(1);
						state_q <= S_TICK_RD;
					end
				end
				S_RATE: begin
					if (rate_below) begin
						if (rate_count_q != 16'hFFFF) begin
							rate_count_q <= rate_count_q + 16'd1;
						end
						rate_ms_q <= sat_sum;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						rate_value_q <= div_quot;
						rate_count_q <= '0;
						rate_ms_q    <= '0;
						state_q      <= S_FIN;
					end
				end
				S_ALLOC: begin
					if (!in_use_q[idx_q]) begin
						in_use_q[idx_q]  <= 1'b1;
						running_q[idx_q] <= 1'b0;
						state_q          <= S_FIN;
					end else if (idx_q == IDX_LAST) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_EXEC: begin
					if (!slot_live) begin
						state_q <= S_FIN;
					end else begin
						unique case (cmd_q)
							CMD_FREE: begin
								in_use_q[slot_idx]  <= 1'b0;
								running_q[slot_idx] <= 1'b0;
								state_q             <= S_FIN;
							end
							CMD_START: begin
								running_q[slot_idx] <= 1'b1;
								state_q             <= S_READ;
							end
							CMD_STOP: begin
								running_q[slot_idx] <= 1'b0;
								state_q             <= S_READ;
							end
							default: state_q <= S_READ;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working result and response payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_accept) begin
					cmd_q          <= cmd_t'(command);
					slot_q         <= slot;
					value_q        <= value;
					res_status_q   <= ST_OK;
					res_slot_q     <= (command == CMD_TICK || command == CMD_ALLOC) ?
						4'd0 : slot;
					res_expired_q  <= 1'b0;
					res_enabled_q  <= 1'b0;
					res_elapsed_q  <= '0;
					res_interval_q <= '0;
				end
			end
			S_RATE: begin
				prod_q <= DIVIDEND_W'(rate_count_q) * RATE_SCALE;
			end
			S_ALLOC: begin
				if (!in_use_q[idx_q]) begin
					res_slot_q     <= 4'(idx_q);
					res_expired_q  <= (value_q == 32'd0);
					res_interval_q <= value_q;
				end else if (idx_q == IDX_LAST) begin
					res_status_q <= ST_NO_FREE;
				end
			end
			S_EXEC: begin
				if (!slot_live) begin
					res_status_q <= ST_NOT_ALLOC;
				end
			end
			S_REPORT: begin
				res_expired_q  <= rd_elapsed >= rd_interval;
				res_enabled_q  <= running_q[slot_idx];
				res_elapsed_q  <= rd_elapsed;
				res_interval_q <= rd_interval;
			end
			S_FIN: begin
				if (out_free) begin
					status_q      <= res_status_q;
					result_slot_q <= res_slot_q;
					expired_q     <= res_expired_q;
					enabled_q     <= res_enabled_q;
					elapsed_q     <= res_elapsed_q;
					interval_q    <= res_interval_q;
					frame_time_q  <= frame_delta_q;
					frame_rate_q  <= rate_value_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign result_slot = result_slot_q;
	assign expired     = expired_q;
	assign enabled     = enabled_q;
	assign elapsed     = elapsed_q;
	assign interval    = interval_q;
	assign frame_time  = frame_time_q;
	assign frame_rate  = frame_rate_q;

`ifndef SYNTH
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a command transaction");

	a_running_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(running_q & ~in_use_q) == '0)
		else $error("a free slot is marked running");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside the rate update");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("response raised outside the finish step");
`endif

endmodule

`default_nettype wire

FILE: dv/tb.sv
// tb: self-checking testbench for frame_timer_bank, a bank of frame-driven elapsed timers
// drives commands and APB writes, predicts every response in-line and checks each field
// depends on ftb_pkg and frame_timer_bank only
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ftb_pkg::*;

	localparam int NUM_SLOTS = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [31:0] FRAME_CLAMP_MS = 32'd1000;
	localparam logic [31:0] CLAMPED_FRAME_MS = 32'd16;
	localparam logic [31:0] RATE_WINDOW_MS = 32'd1000;
	localparam logic [63:0] FPS_SCALE_8P8 = 64'd256000;

	typedef struct packed {
		status_t     st;
		logic [3:0]  rslot;
		logic        expired_f;
		logic        enabled_f;
		logic [31:0] elapsed_f;
		logic [31:0] interval_f;
		logic [31:0] frame_f;
		logic [15:0] rate_f;
	} timer_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [2:0] command = '0;
	logic [3:0] slot = '0;
	logic [31:0] value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] status;
	logic [3:0] result_slot;
	logic expired;
	logic enabled;
	logic [31:0] elapsed;
	logic [31:0] interval;
	logic [31:0] frame_time;
	logic [15:0] frame_rate;

	// predicted block state
	bit clamp_on = 1'b0;
	logic [31:0] last_ms = '0;
	logic [31:0] frame_ms = '0;
	logic [15:0] rate_frames = '0;
	logic [31:0] rate_ms = '0;
	logic [15:0] rate_fps = '0;
	bit in_use [NUM_SLOTS];
	bit running [NUM_SLOTS];
	logic [31:0] elapsed_ms [NUM_SLOTS];
	logic [31:0] interval_ms [NUM_SLOTS];

	timer_rsp_t pending_rsp [$];
	timer_rsp_t want_rsp;
	int mismatches = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_left = 0;
	int cycle_count;

	frame_timer_bank #(.TIMER_SLOTS(NUM_SLOTS)) dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic timer_rsp_t with_slot(timer_rsp_t r, int idx);
		r.rslot = idx[3:0];
		r.expired_f = elapsed_ms[idx] >= interval_ms[idx];
		r.enabled_f = running[idx];
		r.elapsed_f = elapsed_ms[idx];
		r.interval_f = interval_ms[idx];
		return r;
	endfunction

	// advances the predicted bank by one command and returns its response
	function automatic timer_rsp_t timer_bank_step(cmd_t c, logic [3:0] s, logic [31:0] v);
		timer_rsp_t r;
		logic [31:0] ft;
		logic [63:0] q;
		bit found;
		r = '0;
		case (c)
			CMD_TICK: begin
				ft = v - last_ms;
				last_ms = v;
				if (clamp_on && ft > FRAME_CLAMP_MS)
					ft = CLAMPED_FRAME_MS;
				frame_ms = ft;
				for (int i = 0; i < NUM_SLOTS; i++)
					if (in_use[i] && running[i])
						elapsed_ms[i] = sat_add32(elapsed_ms[i], ft);
				if (rate_ms < RATE_WINDOW_MS) begin
					if (rate_frames != 16'hFFFF)
						rate_frames++;
					rate_ms = sat_add32(rate_ms, ft);
				end else begin
					// the frame closing the window is not counted
					q = (64'(rate_frames) * FPS_SCALE_8P8) / 64'(rate_ms);
					rate_fps = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
					rate_frames = '0;
					rate_ms = '0;
				end
			end
			CMD_ALLOC: begin
				found = 1'b0;
				for (int i = 0; i < NUM_SLOTS; i++)
					if (!found && !in_use[i]) begin
						found = 1'b1;
						in_use[i] = 1'b1;
						running[i] = 1'b0;
						elapsed_ms[i] = '0;
						interval_ms[i] = v;
						r = with_slot(r, i);
					end
				if (!found)
					r.st = ST_NO_FREE;
			end
			CMD_NOP: r.rslot = s;
			default: begin
				if (!in_use[s]) begin
					r.st = ST_NOT_ALLOC;
					r.rslot = s;
				end else if (c == CMD_FREE) begin
					in_use[s] = 1'b0;
					running[s] = 1'b0;
					r.rslot = s;
				end else begin
					if (c == CMD_START)
						running[s] = 1'b1;
					else if (c == CMD_STOP)
						running[s] = 1'b0;
					else if (c == CMD_RESET)
						elapsed_ms[s] = '0;
					r = with_slot(r, s);
				end
			end
		endcase
		r.frame_f = frame_ms;
		r.rate_f = rate_fps;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response transaction, slot",
					32'(result_slot), 32'd0);
			end else begin
				want_rsp = pending_rsp.pop_front();
				if (status !== want_rsp.st)
					report_mismatch("status", 32'(status), 32'(want_rsp.st));
				if (result_slot !== want_rsp.rslot)
					report_mismatch("result_slot", 32'(result_slot), 32'(want_rsp.rslot));
				if (expired !== want_rsp.expired_f)
					report_mismatch("expired", 32'(expired), 32'(want_rsp.expired_f));
				if (enabled !== want_rsp.enabled_f)
					report_mismatch("enabled", 32'(enabled), 32'(want_rsp.enabled_f));
				if (elapsed !== want_rsp.elapsed_f)
					report_mismatch("elapsed", elapsed, want_rsp.elapsed_f);
				if (interval !== want_rsp.interval_f)
					report_mismatch("interval", interval, want_rsp.interval_f);
				if (frame_time !== want_rsp.frame_f)
					report_mismatch("frame_time", frame_time, want_rsp.frame_f);
				if (frame_rate !== want_rsp.rate_f)
					report_mismatch("frame_rate", 32'(frame_rate), 32'(want_rsp.rate_f));
			end
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		rsp_stall <= (hold_left != 0) || ($urandom_range(99) < rsp_stall_pct);
	end

	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_cmd(cmd_t c, logic [3:0] s, logic [31:0] v);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		slot <= s;
		value <= v;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pending_rsp.push_back(timer_bank_step(c, s, v));
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_clamp(bit on);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * REG_DEBUG_CLAMP);
		pwdata <= {31'b0, on};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		clamp_on = on;
	endtask

	// mostly an allocated slot, sometimes any slot
	function automatic logic [3:0] pick_slot();
		int live [$];
		for (int i = 0; i < NUM_SLOTS; i++)
			if (in_use[i])
				live.push_back(i);
		if (live.size() != 0 && $urandom_range(99) < 85)
			return 4'(live[$urandom_range(live.size() - 1)]);
		return 4'($urandom_range(NUM_SLOTS - 1));
	endfunction

	function automatic logic [31:0] next_tick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return last_ms + $urandom_range(60);
		if (roll < 92)
			return last_ms + $urandom_range(1100, 900);
		return $urandom();
	endfunction

	task automatic send_random_item();
		int roll;
		cmd_t c;
		logic [31:0] v;
		roll = $urandom_range(99);
		if (roll < 30) c = CMD_TICK;
		else if (roll < 44) c = CMD_ALLOC;
		else if (roll < 54) c = CMD_FREE;
		else if (roll < 66) c = CMD_START;
		else if (roll < 74) c = CMD_STOP;
		else if (roll < 81) c = CMD_RESET;
		else if (roll < 96) c = CMD_QUERY;
		else c = CMD_NOP;
		v = $urandom();
		if (c == CMD_TICK)
			v = next_tick_value();
		else if (c == CMD_ALLOC && $urandom_range(99) < 70)
			v = $urandom_range(400);
		send_cmd(c, pick_slot(), v);
	endtask

	task automatic test_directed_ops();
		send_cmd(CMD_QUERY, 4'd0, 32'd0);
		send_cmd(CMD_START, 4'd7, 32'd0);
		send_cmd(CMD_NOP, 4'd15, 32'hFFFF_FFFF);
		send_cmd(CMD_ALLOC, 4'd9, 32'd0);
		send_cmd(CMD_ALLOC, 4'd0, 32'hFFFF_FFFF);
		send_cmd(CMD_ALLOC, 4'd0, 32'd50);
		send_cmd(CMD_START, 4'd2, 32'd0);
		send_cmd(CMD_START, 4'd1, 32'd0);
		send_cmd(CMD_TICK, 4'd0, 32'd30);
		send_cmd(CMD_QUERY, 4'd2, 32'd0);
		send_cmd(CMD_TICK, 4'd0, 32'd80);
		send_cmd(CMD_STOP, 4'd2, 32'd0);
		send_cmd(CMD_TICK, 4'd0, 32'd100);
		send_cmd(CMD_QUERY, 4'd2, 32'd0);
		send_cmd(CMD_RESET, 4'd2, 32'd0);
		send_cmd(CMD_FREE, 4'd0, 32'd0);
		send_cmd(CMD_QUERY, 4'd0, 32'd0);
		send_cmd(CMD_ALLOC, 4'd0, 32'd7);
		// wrap to the top of the ms counter, then saturate slot 1
		send_cmd(CMD_TICK, 4'd0, 32'hFFFF_FFFF);
		send_cmd(CMD_TICK, 4'd0, 32'd0);
		send_cmd(CMD_QUERY, 4'd1, 32'd0);
		send_cmd(CMD_STOP, 4'd1, 32'd0);
		send_cmd(CMD_FREE, 4'd1, 32'd0);
		send_cmd(CMD_FREE, 4'd1, 32'd0);
	endtask

	task automatic test_clamp_edges();
		wait_idle();
		write_clamp(1'b1);
		send_cmd(CMD_START, 4'd0, 32'd0);
		send_cmd(CMD_TICK, 4'd0, last_ms + FRAME_CLAMP_MS);
		send_cmd(CMD_TICK, 4'd0, last_ms + FRAME_CLAMP_MS + 32'd1);
		send_cmd(CMD_TICK, 4'd0, last_ms - 32'd1);
		send_cmd(CMD_QUERY, 4'd0, 32'd0);
		wait_idle();
		write_clamp(1'b0);
		send_cmd(CMD_TICK, 4'd0, last_ms + FRAME_CLAMP_MS + 32'd1);
		send_cmd(CMD_QUERY, 4'd0, 32'd0);
	endtask

	task automatic test_fill_and_drain();
		int base;
		send_idle_pct = 77;
		base = $urandom_range(NUM_SLOTS - 1);
		for (int i = 0; i < NUM_SLOTS; i++)
			if (in_use[(base + i) % NUM_SLOTS])
				send_cmd(CMD_FREE, 4'((base + i) % NUM_SLOTS), $urandom());
		// the last two allocates find the table full
		repeat (NUM_SLOTS + 1)
			send_cmd(CMD_ALLOC, 4'($urandom()), $urandom_range(300));
		send_cmd(CMD_ALLOC, 4'($urandom()), $urandom());
	endtask

	task automatic test_rate_saturation();
		send_idle_pct = 0;
		while (rate_ms != 0 || rate_frames != 0)
			send_cmd(CMD_TICK, 4'd0, last_ms + RATE_WINDOW_MS);
		repeat (300)
			send_cmd(CMD_TICK, 4'd0, last_ms);
		send_cmd(CMD_TICK, 4'd0, last_ms + RATE_WINDOW_MS);
		send_cmd(CMD_TICK, 4'd0, last_ms);
		send_cmd(CMD_QUERY, pick_slot(), 32'd0);
	endtask

	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_left <= 400;
		repeat (40)
			send_random_item();
	endtask

	task automatic test_random_traffic();
		int idle_by_phase [4] = '{0, 77, 0, 32};
		int stall_by_phase [4] = '{0, 0, 77, 32};
		bit clamp_by_phase [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_clamp(clamp_by_phase[p]);
			send_idle_pct = idle_by_phase[p];
			rsp_stall_pct = stall_by_phase[p];
			repeat (60)
				send_random_item();
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			in_use[i] = 1'b0;
			running[i] = 1'b0;
			elapsed_ms[i] = '0;
			interval_ms[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_ops();
		test_clamp_edges();
		test_fill_and_drain();
		test_rate_saturation();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
